/* rtl/core/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
// Request codes, internal operation codes, status codes and the command word.
// No dependencies.
`default_nettype none

package dq_pkg;

	// Request codes as they arrive on req_type.
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_REMOVE     = 3'd4;
	localparam logic [2:0] REQ_COUNT      = 3'd5;

	// Internal operation codes after classification.
	typedef logic [2:0] op_t;
	localparam op_t OP_PUSH_BACK  = 3'd0;
	localparam op_t OP_PUSH_FRONT = 3'd1;
	localparam op_t OP_POP_BACK   = 3'd2;
	localparam op_t OP_POP_FRONT  = 3'd3;
	localparam op_t OP_REMOVE     = 3'd4;
	localparam op_t OP_COUNT      = 3'd5;
	localparam op_t OP_NOP        = 3'd6;

	// Status codes returned with every result.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Depth of the command queue between front and back.
	localparam int CQ_DEPTH = 2;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/core/double_ended_queue_top.sv */
// Top level of the double-ended queue. Instantiates dq_front, dq_cmd_fifo and dq_back;
// depends on dq_pkg.
`default_nettype none

// A bounded double-ended queue of up to DEPTH 32-bit entries held in a ring memory.
// Each request pushes at the back or front, pops from the back or front, removes the
// first entry (counted from the front) equal to item_value, or counts the entries equal
// to item_value, and every request returns exactly one result in request order. The
// result carries the popped value (zero unless a pop succeeded), the match count (zero
// unless a count request), the queue length after the request, and a status: ok, empty
// on pop, full on push, or value not found on remove. Requests that fail change
// nothing, and codes six and seven return ok without effect. A two-entry command queue
// sits between the request decoder and the execution engine, so new requests are taken
// while the engine works and while a result waits on out_stall. In the engine, which
// owns the single-write, single-read memory port, pushes and unused codes need no memory
// read, pops make a registered memory read, a count reads every entry, a remove that
// misses does the same, and a remove that hits scans up to the hit and then closes the
// gap behind it, moving one entry per cycle.
module double_ended_queue_top #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] item_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_value,
	output logic [4:0]       match_count,
	output logic [4:0]       queue_length,
	output logic [1:0]       status
);
	import dq_pkg::*;

	// Length reported on a full push, taken modulo 32 like every count.
	localparam logic [4:0] FULL_LEN = 5'(DEPTH);

	logic cmd_full;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_valid;
	cmd_t front_cmd;
	cmd_t back_cmd;

	// Request decoder: classifies each request and hands it to the command queue.
	dq_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.item_value (item_value),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd_out    (front_cmd)
	);

	// Command queue: lets the decoder keep taking requests during long scans.
	dq_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.pop_cmd  (back_cmd),
		.valid    (cmd_valid)
	);

	// Execution engine: ring memory, pointers, scans, shifts and the result register.
	dq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (back_cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.match_count  (match_count),
		.queue_length (queue_length),
		.status       (status)
	);

	// An accepted request is waiting for the engine on the next cycle at the latest.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> cmd_valid)
		else $error("accepted request did not reach the command queue");

	// A push refused for lack of room reports a full queue.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> queue_length == FULL_LEN)
		else $error("full status with a queue that is not full");

	// A pop refused on an empty queue reports length zero and no value.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> queue_length == 5'd0 && out_value == 32'd0)
		else $error("empty status with a queue that is not empty");

	// A failed remove carries neither a value nor a count.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOT_FOUND |-> match_count == 5'd0 && out_value == 32'd0)
		else $error("not-found result carries a value or a count");

endmodule

`default_nettype wire

/* rtl/core/dq_front.sv */
// Front end of the double-ended queue: accepts requests and classifies them.
// Depends on dq_pkg; feeds dq_cmd_fifo.
`default_nettype none

module dq_front (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] item_value,
	input  wire logic        cmd_full,
	output logic             cmd_push,
	output dq_pkg::cmd_t     cmd_out
);
	import dq_pkg::*;

	op_t op;

	always_comb begin
		unique case (req_type)
			REQ_PUSH_BACK:  op = OP_PUSH_BACK;
			REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
			REQ_POP_BACK:   op = OP_POP_BACK;
			REQ_POP_FRONT:  op = OP_POP_FRONT;
			REQ_REMOVE:     op = OP_REMOVE;
			REQ_COUNT:      op = OP_COUNT;
			default:        op = OP_NOP;
		endcase
	end

	assign in_stall      = cmd_full;
	assign cmd_push      = in_valid && !cmd_full;
	assign cmd_out.op    = op;
	assign cmd_out.value = item_value;

endmodule

`default_nettype wire

/* rtl/core/dq_cmd_fifo.sv */
// Short command queue that decouples the front end from the back end.
// Depends on dq_pkg for the command word and the queue depth.
`default_nettype none

module dq_cmd_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire dq_pkg::cmd_t push_cmd,
	output logic              full,
	input  wire logic         pop,
	output dq_pkg::cmd_t      pop_cmd,
	output logic              valid
);
	import dq_pkg::*;

	localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CQ_DEPTH + 1);

	cmd_t             slot_q [CQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (fill_q == CNT_W'(CQ_DEPTH));
	assign valid   = (fill_q != '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* rtl/core/dq_back.sv */
// Back end of the double-ended queue: ring store, pointers, scan and shift engine,
// and the result register. Depends on dq_pkg; fed by dq_cmd_fifo.
`default_nettype none

module dq_back #(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  wire dq_pkg::cmd_t cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [31:0]       out_value,
	output logic [4:0]        match_count,
	output logic [4:0]        queue_length,
	output logic [1:0]        status
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POP   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [31:0]      entry_mem_q [DEPTH];
	logic [31:0]      rd_data_s1;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] match_q, match_d;
	logic             pend_s1, pend_d;
	logic [CNT_W-1:0] pend_pos_s1, pend_pos_d;
	op_t              op_q, op_d;
	logic [31:0]      val_q, val_d;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [31:0]      mem_wdata;

	logic             fin;
	logic [31:0]      res_value;
	logic [CNT_W-1:0] res_match;
	logic [1:0]       res_status;
	logic             out_free, hit, is_full, is_empty;
	logic [IDX_W-1:0] front_m1, front_p1;

	logic             out_valid_q;
	logic [31:0]      out_value_q;
	logic [4:0]       match_count_q, queue_length_q;
	logic [1:0]       status_q;

	// Ring slot of the entry at a given position counted from the front.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
			input logic [CNT_W-1:0] p);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(f) + (CNT_W+1)'(p);
		if (s >= (CNT_W+1)'(DEPTH))
			s = s - (CNT_W+1)'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

	// Counts are reported modulo 32.
	function automatic logic [4:0] low5(input logic [CNT_W-1:0] x);
		logic [31:0] e;
		e = 32'(x);
		return e[4:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign hit      = pend_s1 && (rd_data_s1 == val_q);
	assign front_m1 = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign front_p1 = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);

	always_comb begin
		state_d    = state_q;
		front_d    = front_q;
		count_d    = count_q;
		pos_d      = pos_q;
		match_d    = match_q;
		pend_d     = pend_s1;
		pend_pos_d = pend_pos_s1;
		op_d       = op_q;
		val_d      = val_q;
		cmd_pop    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = cmd.value;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		fin        = 1'b0;
		res_value  = '0;
		res_match  = '0;
		res_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					op_d    = cmd.op;
					val_d   = cmd.value;
					pos_d   = '0;
					match_d = '0;
					pend_d  = 1'b0;
					case (cmd.op) inside
						OP_PUSH_BACK: begin
							fin = 1'b1;
							if (is_full) begin
								res_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_of(front_q, count_q);
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_PUSH_FRONT: begin
							fin = 1'b1;
							if (is_full) begin
								res_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = front_m1;
								front_d   = front_m1;
								count_d   = count_q + CNT_W'(1);
							end
						end
						OP_POP_BACK, OP_POP_FRONT: begin
							if (is_empty) begin
								fin        = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = (cmd.op == OP_POP_BACK) ?
									slot_of(front_q, count_q - CNT_W'(1)) : front_q;
								state_d   = S_POP;
							end
						end
						OP_REMOVE, OP_COUNT: begin
							state_d = S_SCAN;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				fin       = 1'b1;
				res_value = rd_data_s1;
				count_d   = count_q - CNT_W'(1);
				if (op_q == OP_POP_FRONT)
					front_d = front_p1;
				state_d   = S_IDLE;
			end
			S_SCAN: begin
				if (pos_q < count_q) begin
					mem_re     = 1'b1;
					mem_raddr  = slot_of(front_q, pos_q);
					pos_d      = pos_q + CNT_W'(1);
					pend_d     = 1'b1;
					pend_pos_d = pos_q;
				end else begin
					pend_d = 1'b0;
				end
				if (hit && op_q == OP_COUNT)
					match_d = match_q + CNT_W'(1);
				if (hit && op_q == OP_REMOVE) begin
					// First match found: close the gap from the next entry on.
					state_d = S_SHIFT;
					pos_d   = pend_pos_s1 + CNT_W'(1);
					pend_d  = 1'b0;
				end else if (!pend_s1 && pos_q >= count_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (op_q == OP_REMOVE)
						res_status = ST_NOT_FOUND;
					else
						res_match = match_q;
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = slot_of(front_q, pend_pos_s1);
					mem_wdata = rd_data_s1;
				end
				if (pos_q < count_q) begin
					mem_re     = 1'b1;
					mem_raddr  = slot_of(front_q, pos_q);
					pos_d      = pos_q + CNT_W'(1);
					pend_d     = 1'b1;
					pend_pos_d = pos_q - CNT_W'(1);
				end else begin
					pend_d = 1'b0;
				end
				if (!pend_s1 && pos_q >= count_q) begin
					fin     = 1'b1;
					count_d = count_q - CNT_W'(1);
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			match_q     <= '0;
			pend_s1     <= 1'b0;
			pend_pos_s1 <= '0;
			op_q        <= OP_NOP;
			val_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			pos_q       <= pos_d;
			match_q     <= match_d;
			pend_s1     <= pend_d;
			pend_pos_s1 <= pend_pos_d;
			op_q        <= op_d;
			val_q       <= val_d;
			if (fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_value_q    <= res_value;
			match_count_q  <= low5(res_match);
			queue_length_q <= low5(count_d);
			status_q       <= res_status;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			entry_mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_s1 <= entry_mem_q[mem_raddr];
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign match_count  = match_count_q;
	assign queue_length = queue_length_q;
	assign status       = status_q;

endmodule

`default_nettype wire
